// ===== hdl/mbe_pkg.sv =====
// Shared constants, types and command/status bundles of the multipart body extractor.
`timescale 1ns / 1ps

package mbe_pkg;

    // Longest boundary line that is accepted
    localparam int MAX_BOUNDARY = 64;
    // Terminator window: CRLF plus the boundary
    localparam int WIN_DEPTH    = MAX_BOUNDARY + 2;
    // Payload bytes held back at most
    localparam int HOLD_DEPTH   = MAX_BOUNDARY + 1;
    localparam int LEN_W        = $clog2(MAX_BOUNDARY + 1);
    localparam int CNT_W        = $clog2(HOLD_DEPTH + 1);

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        PH_BOUNDARY = 2'd0,
        PH_HEADERS  = 2'd1,
        PH_PAYLOAD  = 2'd2,
        PH_FINISHED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_BEGIN    = 2'd1,
        KIND_COMPLETE = 2'd2,
        KIND_FAILED   = 2'd3
    } kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  take_line;    // count a line byte
        logic  keep_byte;    // also store it as a boundary byte
        logic  latch_len;    // line length becomes the boundary length
        logic  clear_line;   // restart line counting
        logic  clear_window; // empty the payload window
        logic  hold;         // append the byte to the window
        logic  shift;        // emit the oldest byte and append the new one
        logic  emit;         // load the output register
        kind_t kind;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic line_empty;
        logic line_ovf;
        logic win_full;
        logic match;
    } stat_t;

endpackage

// ===== hdl/mbe_ctrl.sv =====
// Phase controller of the multipart body extractor.
`timescale 1ns / 1ps

module mbe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  mbe_pkg::stat_t stat,
    output mbe_pkg::cmd_t  cmd
);

    mbe_pkg::phase_t state_reg;
    mbe_pkg::phase_t state_next;

    // Hold the phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbe_pkg::PH_BOUNDARY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the phase on line ends and on the terminator
    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            case (state_reg)
                mbe_pkg::PH_BOUNDARY:
                begin
                    if (stat.is_lf)
                    begin
                        state_next = (stat.line_ovf || stat.line_empty) ?
                                     mbe_pkg::PH_FINISHED : mbe_pkg::PH_HEADERS;
                    end
                end
                mbe_pkg::PH_HEADERS:
                begin
                    if (stat.is_lf && stat.line_empty)
                    begin
                        state_next = mbe_pkg::PH_PAYLOAD;
                    end
                end
                mbe_pkg::PH_PAYLOAD:
                begin
                    if (stat.win_full && stat.match)
                    begin
                        state_next = mbe_pkg::PH_FINISHED;
                    end
                end
                mbe_pkg::PH_FINISHED:
                begin
                    state_next = mbe_pkg::PH_FINISHED;
                end
                default:
                begin
                    state_next = mbe_pkg::PH_BOUNDARY;
                end
            endcase
        end
    end

    // Drive datapath commands for the accepted item
    always_comb
    begin
        cmd = '0;
        if (accept)
        begin
            case (state_reg)
                mbe_pkg::PH_BOUNDARY:
                begin
                    if (stat.is_lf)
                    begin
                        if (stat.line_ovf || stat.line_empty)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = mbe_pkg::KIND_FAILED;
                        end
                        else
                        begin
                            cmd.latch_len  = 1'b1;
                            cmd.clear_line = 1'b1;
                        end
                    end
                    else if (!stat.is_cr)
                    begin
                        cmd.take_line = 1'b1;
                        cmd.keep_byte = 1'b1;
                    end
                end
                mbe_pkg::PH_HEADERS:
                begin
                    if (stat.is_lf)
                    begin
                        cmd.clear_line = 1'b1;
                        if (stat.line_empty)
                        begin
                            cmd.clear_window = 1'b1;
                            cmd.emit         = 1'b1;
                            cmd.kind         = mbe_pkg::KIND_BEGIN;
                        end
                    end
                    else if (!stat.is_cr)
                    begin
                        cmd.take_line = 1'b1;
                    end
                end
                mbe_pkg::PH_PAYLOAD:
                begin
                    if (!stat.win_full)
                    begin
                        cmd.hold = 1'b1;
                    end
                    else if (stat.match)
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = mbe_pkg::KIND_COMPLETE;
                    end
                    else
                    begin
                        cmd.shift = 1'b1;
                        cmd.emit  = 1'b1;
                        cmd.kind  = mbe_pkg::KIND_BYTE;
                    end
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
    end

    // Finished is final
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbe_pkg::PH_FINISHED |=> state_reg == mbe_pkg::PH_FINISHED)
        else $error("left finished phase");

    // A terminal result ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && (cmd.kind == mbe_pkg::KIND_COMPLETE || cmd.kind == mbe_pkg::KIND_FAILED)
        |=> state_reg == mbe_pkg::PH_FINISHED)
        else $error("terminal result without finishing");

    // Part begin enters the payload phase
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.kind == mbe_pkg::KIND_BEGIN |=> state_reg == mbe_pkg::PH_PAYLOAD)
        else $error("part begin without payload phase");

endmodule

// ===== hdl/mbe_dpath.sv =====
// Line counter, boundary store, payload window, terminator matcher and output register.
`timescale 1ns / 1ps

module mbe_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  mbe_pkg::cmd_t       cmd,
    output mbe_pkg::stat_t      stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [1:0]          out_kind,
    output logic [7:0]          out_byte
);

    logic [mbe_pkg::LEN_W-1:0]     line_len_reg;
    logic                          line_ovf_reg;
    logic [mbe_pkg::LEN_W-1:0]     blen_reg;
    logic [mbe_pkg::CNT_W-1:0]     held_cnt_reg;
    logic [mbe_pkg::WIN_DEPTH-1:0] hit_vec_reg;
    logic [mbe_pkg::WIN_DEPTH-1:0] hit_vec_next;
    logic [mbe_pkg::WIN_DEPTH-1:0] byte_eq;
    logic [7:0]                    bstore_reg [mbe_pkg::MAX_BOUNDARY];
    logic [7:0]                    held_reg [mbe_pkg::HOLD_DEPTH];
    logic [mbe_pkg::CNT_W-1:0]     keep;
    logic                          line_full;
    logic                          match;
    logic                          out_valid_reg;
    logic [1:0]                    out_kind_reg;
    logic [7:0]                    out_byte_reg;

    // Window size less one: boundary plus CRLF minus the incoming byte
    assign keep      = mbe_pkg::CNT_W'(blen_reg) + mbe_pkg::CNT_W'(1);
    assign line_full = (line_len_reg == mbe_pkg::LEN_W'(mbe_pkg::MAX_BOUNDARY));

    // Compare the byte against every terminator position
    always_comb
    begin
        for (int k = 0; k < mbe_pkg::WIN_DEPTH; k++)
        begin
            if (k == 0)
            begin
                byte_eq[k] = (data_byte == mbe_pkg::CHAR_CR);
            end
            else if (k == 1)
            begin
                byte_eq[k] = (data_byte == mbe_pkg::CHAR_LF);
            end
            else
            begin
                byte_eq[k] = (data_byte == bstore_reg[k-2]);
            end
        end
    end

    // Advance the partial-match vector (bit k: last k+1 bytes match the prefix)
    assign hit_vec_next = {hit_vec_reg[mbe_pkg::WIN_DEPTH-2:0], 1'b1} & byte_eq;

    // Pick the full-length match bit
    always_comb
    begin
        match = 1'b0;
        for (int k = 1; k < mbe_pkg::WIN_DEPTH; k++)
        begin
            if (keep == mbe_pkg::CNT_W'(k))
            begin
                match = hit_vec_next[k];
            end
        end
    end

    always_comb
    begin
        stat.is_cr      = (data_byte == mbe_pkg::CHAR_CR);
        stat.is_lf      = (data_byte == mbe_pkg::CHAR_LF);
        stat.line_empty = (line_len_reg == '0);
        stat.line_ovf   = line_ovf_reg;
        stat.win_full   = (held_cnt_reg == keep);
        stat.match      = match;
    end

    // Count line bytes with saturation, latch the boundary length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg <= '0;
            line_ovf_reg <= 1'b0;
            blen_reg     <= '0;
        end
        else
        begin
            if (cmd.latch_len)
            begin
                blen_reg <= line_len_reg;
            end
            if (cmd.clear_line)
            begin
                line_len_reg <= '0;
                line_ovf_reg <= 1'b0;
            end
            else if (cmd.take_line)
            begin
                if (line_full)
                begin
                    line_ovf_reg <= 1'b1;
                end
                else
                begin
                    line_len_reg <= line_len_reg + mbe_pkg::LEN_W'(1);
                end
            end
        end
    end

    // Store boundary bytes at the current line position
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mbe_pkg::MAX_BOUNDARY; i++)
        begin
            if (cmd.take_line && cmd.keep_byte && !line_full &&
                line_len_reg == mbe_pkg::LEN_W'(i))
            begin
                bstore_reg[i] <= data_byte;
            end
        end
    end

    // Track fill level and the match vector of the payload window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= '0;
            hit_vec_reg  <= '0;
        end
        else if (cmd.clear_window)
        begin
            held_cnt_reg <= '0;
            hit_vec_reg  <= '0;
        end
        else if (cmd.hold)
        begin
            held_cnt_reg <= held_cnt_reg + mbe_pkg::CNT_W'(1);
            hit_vec_reg  <= hit_vec_next;
        end
        else if (cmd.shift)
        begin
            hit_vec_reg <= hit_vec_next;
        end
    end

    // Append at the fill level, or shift out the oldest and append at the tail
    for (genvar i = 0; i < mbe_pkg::HOLD_DEPTH; i++)
    begin : g_held
        always_ff @(posedge clk)
        begin
            if (cmd.hold && held_cnt_reg == mbe_pkg::CNT_W'(i))
            begin
                held_reg[i] <= data_byte;
            end
            else if (cmd.shift)
            begin
                if (keep == mbe_pkg::CNT_W'(i + 1))
                begin
                    held_reg[i] <= data_byte;
                end
                else
                begin
                    if (i < mbe_pkg::HOLD_DEPTH - 1)
                    begin
                        held_reg[i] <= held_reg[(i + 1) % mbe_pkg::HOLD_DEPTH];
                    end
                end
            end
        end
    end

    // Load the output register on a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.kind;
            out_byte_reg <= cmd.shift ? held_reg[0] : 8'h00;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;

    // The window never holds more than its size less one
    assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg <= keep)
        else $error("payload window overfilled");

    // A result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || out_ready)
        else $error("result overwritten while stalled");

    // Bytes leave the window only once it is full
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> held_cnt_reg == keep && blen_reg != '0)
        else $error("shift on a window that is not full");

endmodule

// ===== hdl/multipart_body_extractor.sv =====
// Top level of the multipart body extractor: stream ports, controller and datapath.
`timescale 1ns / 1ps
//
// Usage: feed the raw multipart request body, one byte per item, on the
// s_tvalid/s_tready/s_tdata channel. Results leave on m_tvalid/m_tready with
// the kind in m_tuser (payload byte, part begins, complete, failed) and the
// payload byte in m_tdata (zero for the other kinds). The first line is the
// boundary; header lines are skipped up to the blank line, which gives a
// "part begins" item. A payload byte comes out once the boundary length plus
// one later bytes have arrived; the terminator itself is never emitted and
// yields one "complete" item. An empty or over-long boundary line yields "failed".
// After complete or failed, further bytes are consumed without results.
// Throughput: one input byte per cycle while the receiver does not stall; a
// result appears on the output register in the cycle after the byte that causes it.
// The terminator search is a combinational, parallel compare of each byte against
// all boundary positions feeding a shifted partial-match vector.
// Reset clears the phase, counters and output register; no clearing pass.
// When the receiver stalls, the pending result holds and s_tready drops
// until it is taken; a new byte is accepted in the cycle the result leaves.

module multipart_body_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser    // [1:0] out_kind
);

    mbe_pkg::cmd_t  cmd;
    mbe_pkg::stat_t stat;
    logic           accept;

    // Take a byte whenever the output register is free or being emptied
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    mbe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .stat   (stat),
        .cmd    (cmd)
    );

    mbe_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_byte  (m_tdata)
    );

endmodule
